>>> rtl/lkv_pkg.sv
// Shared types and constants for the LRU key-value cache.
package lkv_pkg;

    // Operation codes carried on the cmd field
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // Field widths
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    // Capacity register reset value
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Value returned on a get miss and on every put
    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

    // Request sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } t_state;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        logic compare;  // latch key match for the incoming request
        logic update;   // apply the shift decided from the match pattern
        logic hit;      // some cell matched
        logic insert;   // put on an absent key
    } t_cell_ctrl;

endpackage

>>> rtl/lkv_cell.sv
// One cell of the recency-ordered entry chain: key, value, valid and match flag.
module lkv_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lkv_pkg::t_cell_ctrl           i_ctrl,
    input  logic [lkv_pkg::KEY_W-1:0]     i_cmp_key,
    input  logic [CW-1:0]                 i_lim,
    input  logic [lkv_pkg::KEY_W-1:0]     i_prev_key,
    input  logic [lkv_pkg::VAL_W-1:0]     i_prev_val,
    input  logic                          i_prev_valid,
    input  logic                          i_tail_match,
    output logic [lkv_pkg::KEY_W-1:0]     o_key,
    output logic [lkv_pkg::VAL_W-1:0]     o_val,
    output logic                          o_valid,
    output logic                          o_suffix,
    output logic [lkv_pkg::VAL_W-1:0]     o_hit_val
);

    logic [lkv_pkg::KEY_W-1:0] r_key;
    logic [lkv_pkg::VAL_W-1:0] r_val;
    logic                      r_valid;
    logic                      r_match;
    logic                      w_shift;

    // Match here or further down the chain: this cell moves up one place
    assign o_suffix  = r_match | i_tail_match;
    assign o_hit_val = r_match ? r_val : '0;
    assign o_key     = r_key;
    assign o_val     = r_val;
    assign o_valid   = r_valid;

    // Hit: cells up to the matching one shift; insert: cells up to the limit shift
    always_comb begin
        if (i_ctrl.hit) begin
            w_shift = o_suffix;
        end else begin
            w_shift = i_ctrl.insert && (CW'(IDX) <= i_lim);
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_ctrl.compare) begin
                r_match <= r_valid && (r_key == i_cmp_key);
            end
            if (i_ctrl.update && w_shift) begin
                r_valid <= i_prev_valid;
            end
        end
    end

    // Payload takes the neighbour's entry on a shift
    always_ff @(posedge i_clk) begin
        if (i_ctrl.update && w_shift) begin
            r_key <= i_prev_key;
            r_val <= i_prev_val;
        end
    end

endmodule

>>> rtl/lru_key_value_cache_top.sv
// LRU key-value cache top level: request sequencer, entry chain and result register.
//
// Input channel: i_valid / o_stall with i_cmd (0 get, 1 put), i_key, i_value.
// Output channel: o_valid / i_stall with o_hit and o_read_value.
// Capacity register: written by i_cfg_we / i_cfg_data; the user writes it only while the cache
// is idle, which the block does not enforce. Zero acts as one, values above ENTRIES act as ENTRIES.
// Entries sit in a chain of cells ordered by recency, cell 0 most recent.
// On acceptance the request is registered and every cell compares its key in parallel.
// In the update state hit/miss is resolved; on a hit or a put, cells shift one place towards
// the tail up to the hit cell or the insertion limit and cell 0 takes the request's entry;
// in every case the result is loaded into the output register.
// A new request is taken only after the previous one has finished its compare-then-shift
// pass over the chain.
// A finished result waits in the output register while i_stall is high; the
// next request is taken only once that register is free or being drained.
// Reset (synchronous, i_rst_n low) empties the cache, sets capacity to 16 and
// drops any pending result.
module lru_key_value_cache_top #(
    parameter int ENTRIES = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0]      i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_cmd,
    input  logic signed [lkv_pkg::KEY_W-1:0] i_key,
    input  logic signed [lkv_pkg::VAL_W-1:0] i_value,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_hit,
    output logic signed [lkv_pkg::VAL_W-1:0] o_read_value
);

    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (CW > lkv_pkg::CAP_W) ? CW : lkv_pkg::CAP_W;

    lkv_pkg::t_state             r_state, n_state;
    logic [lkv_pkg::CAP_W-1:0]   r_capacity;
    logic [CW-1:0]               r_count;
    logic                        r_cmd;
    logic [lkv_pkg::KEY_W-1:0]   r_key;
    logic [lkv_pkg::VAL_W-1:0]   r_val;
    logic                        r_out_valid;
    logic                        r_out_hit;
    logic [lkv_pkg::VAL_W-1:0]   r_out_value;

    logic                        w_accept;
    logic                        w_update;
    lkv_pkg::t_cell_ctrl         w_ctrl;
    logic [CMPW-1:0]             w_cap_ext;
    logic [CMPW-1:0]             w_cap_eff;
    logic                        w_full;
    logic [CW-1:0]               w_lim;
    logic [lkv_pkg::VAL_W-1:0]   w_hit_val;
    logic [lkv_pkg::VAL_W-1:0]   w_new_val;

    logic [lkv_pkg::KEY_W-1:0]   w_key   [ENTRIES];
    logic [lkv_pkg::VAL_W-1:0]   w_val   [ENTRIES];
    logic                        w_vld   [ENTRIES];
    logic                        w_suf   [ENTRIES];
    logic [lkv_pkg::VAL_W-1:0]   w_hval  [ENTRIES];

    // Request acceptance: idle and the output register is free by the next edge
    assign w_accept = i_valid && !o_stall;
    assign w_update = (r_state == lkv_pkg::ST_UPDATE);

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lkv_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_stall = 1'b1;
        case (r_state)
            lkv_pkg::ST_IDLE: begin
                o_stall = r_out_valid && i_stall;
                if (i_valid && !o_stall) begin
                    n_state = lkv_pkg::ST_UPDATE;
                end
            end
            lkv_pkg::ST_UPDATE: begin
                n_state = lkv_pkg::ST_IDLE;
            end
            default: begin
                n_state = lkv_pkg::ST_IDLE;
            end
        endcase
    end

    // Effective capacity and the insertion limit
    assign w_cap_ext = CMPW'(r_capacity);
    always_comb begin
        if (w_cap_ext == '0) begin
            w_cap_eff = CMPW'(1);
        end else if (w_cap_ext > CMPW'(ENTRIES)) begin
            w_cap_eff = CMPW'(ENTRIES);
        end else begin
            w_cap_eff = w_cap_ext;
        end
    end
    assign w_full = CMPW'(r_count) >= w_cap_eff;
    // Full: the least recent entry drops off the tail; otherwise the chain grows
    assign w_lim  = w_full ? (r_count - CW'(1)) : r_count;

    // Hit value: at most one cell matches
    always_comb begin
        w_hit_val = '0;
        for (int j = 0; j < ENTRIES; j++) begin
            w_hit_val = w_hit_val | w_hval[j];
        end
    end

    assign w_new_val = (r_cmd == lkv_pkg::CMD_PUT) ? r_val : w_hit_val;

    assign w_ctrl.compare = w_accept;
    assign w_ctrl.update  = w_update;
    assign w_ctrl.hit     = w_suf[0];
    assign w_ctrl.insert  = (r_cmd == lkv_pkg::CMD_PUT) && !w_suf[0];

    // Entry chain
    for (genvar j = 0; j < ENTRIES; j++) begin : g_cell
        logic [lkv_pkg::KEY_W-1:0] w_pkey;
        logic [lkv_pkg::VAL_W-1:0] w_pval;
        logic                      w_pvld;
        logic                      w_tail;

        if (j == 0) begin : g_head
            assign w_pkey = r_key;
            assign w_pval = w_new_val;
            assign w_pvld = 1'b1;
        end else begin : g_body
            assign w_pkey = w_key[j-1];
            assign w_pval = w_val[j-1];
            assign w_pvld = w_vld[j-1];
        end

        if (j == ENTRIES - 1) begin : g_last
            assign w_tail = 1'b0;
        end else begin : g_inner
            assign w_tail = w_suf[j+1];
        end

        lkv_cell #(
            .IDX (j),
            .CW  (CW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_cmp_key    (i_key),
            .i_lim        (w_lim),
            .i_prev_key   (w_pkey),
            .i_prev_val   (w_pval),
            .i_prev_valid (w_pvld),
            .i_tail_match (w_tail),
            .o_key        (w_key[j]),
            .o_val        (w_val[j]),
            .o_valid      (w_vld[j]),
            .o_suffix     (w_suf[j]),
            .o_hit_val    (w_hval[j])
        );
    end

    // Control registers: capacity, entry count, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= lkv_pkg::CAP_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
            if (w_update && w_ctrl.insert && !w_full) begin
                r_count <= r_count + CW'(1);
            end
            if (w_update) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_cmd;
            r_key <= i_key;
            r_val <= i_value;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (w_update) begin
            r_out_hit <= w_suf[0];
            if (w_suf[0] && (r_cmd == lkv_pkg::CMD_GET)) begin
                r_out_value <= w_hit_val;
            end else begin
                r_out_value <= lkv_pkg::MISS_VALUE;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_hit        = r_out_hit;
    assign o_read_value = r_out_value;

endmodule

>>> rtl/lkv_checker.sv
// Port-level checks for the LRU key-value cache, bound to the top level.
module lkv_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_valid,
    input logic                             o_stall,
    input logic                             o_valid,
    input logic                             i_stall,
    input logic                             o_hit,
    input logic signed [lkv_pkg::VAL_W-1:0] o_read_value
);

    // One request in flight: busy in the cycle after a request is taken
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request taken while previous one still in progress");

    // Result appears once the request has passed through the update state into the output register
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> ##1 o_valid)
        else $error("result missing two cycles after request");

    // A miss always reports the miss value
    a_miss_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_read_value == lkv_pkg::MISS_VALUE))
        else $error("miss result carries a stored value");

    // A stalled result holds
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_hit) && $stable(o_read_value)))
        else $error("stalled result changed");

endmodule

bind lru_key_value_cache_top lkv_checker u_lkv_checker (.*);

>>> tb/tb.sv
// Self-checking testbench for the LRU key-value cache: directed corner cases and random get/put traffic.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES        = 16;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int LONG_HOLD      = 150;
    localparam int PHASE_ITEMS    = 72;
    localparam int NUM_PHASES     = 11;
    // capacity per random phase: both extremes, zero, and values past the entry count
    localparam int PHASE_CAP [NUM_PHASES] = '{2, 16, 5, 17, 1, 8, 31, 3, 12, 0, 16};

    typedef struct packed {
        logic                      cmd;
        logic [lkv_pkg::KEY_W-1:0] key;
        logic [lkv_pkg::VAL_W-1:0] value;
    } t_cache_req;

    typedef struct packed {
        logic                      hit;
        logic [lkv_pkg::VAL_W-1:0] read_value;
    } t_cache_rsp;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_we = 1'b0;
    logic [lkv_pkg::CAP_W-1:0]        i_cfg_data = '0;
    logic                             i_valid = 1'b0;
    logic                             o_stall;
    logic                             i_cmd = lkv_pkg::CMD_GET;
    logic signed [lkv_pkg::KEY_W-1:0] i_key = '0;
    logic signed [lkv_pkg::VAL_W-1:0] i_value = '0;
    logic                             o_valid;
    logic                             i_stall = 1'b0;
    logic                             o_hit;
    logic signed [lkv_pkg::VAL_W-1:0] o_read_value;

    lru_key_value_cache_top #(.ENTRIES(ENTRIES)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_key        (i_key),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hit        (o_hit),
        .o_read_value (o_read_value)
    );

    always #4 i_clk = ~i_clk;

    // Requests waiting to be offered and results still owed by the cache
    t_cache_req  request_queue [$];
    t_cache_rsp  expected_results [$];
    int          outstanding = 0;

    // Shadow copy of the cache contents and capacity register
    logic [lkv_pkg::KEY_W-1:0] shadow_key   [ENTRIES];
    logic [lkv_pkg::VAL_W-1:0] shadow_value [ENTRIES];
    bit                        shadow_valid [ENTRIES];
    int                        shadow_rank  [ENTRIES];
    int                        shadow_count = 0;
    logic [lkv_pkg::CAP_W-1:0] cap_setting  = lkv_pkg::CAP_RESET;

    // Run control and tallies
    logic sender_bursty   = 1'b1;
    logic receiver_bursty = 1'b1;
    logic calm            = 1'b0;
    logic long_hold_req   = 1'b0;
    int   mismatches = 0;
    int   n_requests = 0;
    int   n_puts     = 0;
    int   n_results  = 0;
    int   n_hits     = 0;
    int   n_evicts   = 0;
    int   quiet_cycles = 0;

    function automatic int effective_capacity(input logic [lkv_pkg::CAP_W-1:0] c);
        if (c == 0) return 1;
        if (c > ENTRIES) return ENTRIES;
        return int'(c);
    endfunction

    // Move a slot to the front; entries ahead of it (or all, for a fresh slot) age by one
    function automatic void make_most_recent(input int slot, input bit was_valid);
        int r;
        r = shadow_rank[slot];
        for (int i = 0; i < ENTRIES; i++) begin
            if (i != slot && shadow_valid[i] && (!was_valid || shadow_rank[i] < r))
                shadow_rank[i]++;
        end
        shadow_rank[slot] = 0;
    endfunction

    // Apply one request to the shadow cache and return the result it should produce
    function automatic t_cache_rsp lru_access(input logic cmd,
                                              input logic [lkv_pkg::KEY_W-1:0] key,
                                              input logic [lkv_pkg::VAL_W-1:0] value);
        t_cache_rsp rsp;
        int slot;
        int oldest;
        bit found;
        slot  = 0;
        found = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (!found && shadow_valid[i] && shadow_key[i] == key) begin
                slot  = i;
                found = 1'b1;
            end
        end
        rsp.hit        = found;
        rsp.read_value = lkv_pkg::MISS_VALUE;
        if (found) begin
            make_most_recent(slot, 1'b1);
            if (cmd == lkv_pkg::CMD_GET) rsp.read_value = shadow_value[slot];
            else shadow_value[slot] = value;
            return rsp;
        end
        if (cmd == lkv_pkg::CMD_GET) return rsp;
        if (shadow_count >= effective_capacity(cap_setting)) begin
            // full: overwrite the least recent entry where it sits
            oldest = -1;
            for (int i = 0; i < ENTRIES; i++) begin
                if (shadow_valid[i] && shadow_rank[i] > oldest) begin
                    oldest = shadow_rank[i];
                    slot   = i;
                end
            end
            shadow_key[slot]   = key;
            shadow_value[slot] = value;
            make_most_recent(slot, 1'b1);
            n_evicts++;
        end else begin
            for (int i = ENTRIES - 1; i >= 0; i--) begin
                if (!shadow_valid[i]) slot = i;
            end
            shadow_key[slot]   = key;
            shadow_value[slot] = value;
            make_most_recent(slot, 1'b0);
            shadow_valid[slot] = 1'b1;
            shadow_count++;
        end
        return rsp;
    endfunction

    task automatic flag_mismatch(input string what, input logic [lkv_pkg::VAL_W-1:0] want,
                                 input logic [lkv_pkg::VAL_W-1:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    task automatic queue_request(input logic cmd, input logic [lkv_pkg::KEY_W-1:0] key,
                                 input logic [lkv_pkg::VAL_W-1:0] value);
        t_cache_req req;
        req.cmd   = cmd;
        req.key   = key;
        req.value = value;
        request_queue.push_back(req);
    endtask

    // Hold until every request is answered, then let the pipeline settle
    task automatic wait_drained();
        while (request_queue.size() != 0 || outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [lkv_pkg::CAP_W-1:0] cap);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= cap;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cap_setting = cap;
    endtask

    // Request driver: predicts on acceptance, holds a stalled request, idles in bursts
    always @(posedge i_clk) begin : request_driver
        t_cache_req nxt;
        int gap_left;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_results.push_back(lru_access(i_cmd, i_key, i_value));
                n_requests++;
                if (i_cmd == lkv_pkg::CMD_PUT) n_puts++;
            end
            if (i_valid && o_stall) begin
                // stalled request stays on the bus unchanged
            end else if (gap_left != 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (sender_bursty && !calm && $urandom_range(0, 5) == 0) begin
                gap_left = $urandom_range(0, 9);
                i_valid <= 1'b0;
            end else if (request_queue.size() != 0) begin
                nxt = request_queue.pop_front();
                outstanding++;
                i_valid <= 1'b1;
                i_cmd   <= nxt.cmd;
                i_key   <= nxt.key;
                i_value <= nxt.value;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result monitor: checks each result against the oldest prediction and drives stall
    always @(posedge i_clk) begin : result_monitor
        t_cache_rsp want;
        int stall_left;
        bit long_hold_done;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
            long_hold_done = 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                n_results++;
                outstanding--;
                if (o_hit) n_hits++;
                if (expected_results.size() == 0) begin
                    flag_mismatch("result with no request pending", 'x, o_read_value);
                end else begin
                    want = expected_results.pop_front();
                    if (o_hit !== want.hit)
                        flag_mismatch("hit", lkv_pkg::VAL_W'(want.hit),
                                      lkv_pkg::VAL_W'(o_hit));
                    if (o_read_value !== want.read_value)
                        flag_mismatch("read_value", want.read_value, o_read_value);
                end
            end
            if (long_hold_req && !long_hold_done) begin
                // one long hold-off so the cache backs up into the sender
                long_hold_done = 1'b1;
                stall_left = LONG_HOLD - 1;
                i_stall <= 1'b1;
            end else if (stall_left != 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (receiver_bursty && !calm && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 9);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog: ends the run if nothing moves on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no handshake for %0d cycles, %0d requests unanswered",
                         WATCHDOG_LIMIT, outstanding);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Stimulus: directed corner cases, then random phases over a range of capacities
    initial begin
        logic [lkv_pkg::KEY_W-1:0] key_pool [$];
        logic [lkv_pkg::KEY_W-1:0] key;
        logic [lkv_pkg::VAL_W-1:0] value;
        logic                      cmd;
        int                        pool_len;
        int                        eff;

        for (int i = 0; i < ENTRIES; i++) begin
            shadow_key[i]   = '0;
            shadow_value[i] = '0;
            shadow_valid[i] = 1'b0;
            shadow_rank[i]  = 0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty cache, key and value extremes, a stored -1 that must still hit
        queue_request(lkv_pkg::CMD_GET, 32'h0000_0000, 32'h1234_5678);
        queue_request(lkv_pkg::CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_request(lkv_pkg::CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_request(lkv_pkg::CMD_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_request(lkv_pkg::CMD_GET, 32'h0000_0000, 32'h0);
        queue_request(lkv_pkg::CMD_GET, 32'h8000_0000, 32'h0);
        queue_request(lkv_pkg::CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        queue_request(lkv_pkg::CMD_PUT, 32'h0000_0000, 32'h0000_0000);
        queue_request(lkv_pkg::CMD_GET, 32'h0000_0000, 32'h0);
        queue_request(lkv_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0);

        // capacity below the current fill: puts replace the oldest entry in place
        write_capacity(5'd1);
        queue_request(lkv_pkg::CMD_PUT, 32'h0000_0055, 32'hAAAA_AAAA);
        queue_request(lkv_pkg::CMD_GET, 32'h8000_0000, 32'h0);
        queue_request(lkv_pkg::CMD_GET, 32'h0000_0055, 32'h0);
        queue_request(lkv_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'h5555_5555);
        queue_request(lkv_pkg::CMD_GET, 32'h7FFF_FFFF, 32'h0);

        // capacity zero behaves as one
        write_capacity(5'd0);
        queue_request(lkv_pkg::CMD_PUT, 32'h0000_0001, 32'h0000_0001);
        queue_request(lkv_pkg::CMD_PUT, 32'h0000_0002, 32'h0000_0002);
        queue_request(lkv_pkg::CMD_GET, 32'h0000_0001, 32'h0);
        queue_request(lkv_pkg::CMD_GET, 32'h0000_0002, 32'h0);

        // capacity above the entry count saturates
        write_capacity(5'd31);
        queue_request(lkv_pkg::CMD_PUT, 32'h0000_0003, 32'h0000_0003);
        queue_request(lkv_pkg::CMD_PUT, 32'h0000_0002, 32'hFFFF_FFFF);
        queue_request(lkv_pkg::CMD_GET, 32'h0000_0002, 32'h0);
        queue_request(lkv_pkg::CMD_GET, 32'h0000_0055, 32'h0);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_capacity(lkv_pkg::CAP_W'(PHASE_CAP[ph]));
            eff = effective_capacity(cap_setting);
            calm            <= (ph == NUM_PHASES - 1);
            sender_bursty   <= (ph != 1) && ($urandom_range(0, 3) != 0);
            receiver_bursty <= ($urandom_range(0, 3) != 0);
            if (ph == 1) long_hold_req <= 1'b1;

            // a key set from the capacity up to twice it plus two gives both hits and evictions
            key_pool.delete();
            pool_len = $urandom_range(eff, 2 * eff + 2);
            for (int j = 0; j < pool_len; j++) key_pool.push_back($urandom);
            if ($urandom_range(0, 1) == 0) key_pool[0] = 32'h8000_0000;
            if ($urandom_range(0, 1) == 0) key_pool[pool_len - 1] = 32'h7FFF_FFFF;

            for (int j = 0; j < PHASE_ITEMS; j++) begin
                cmd = ($urandom_range(0, 1) == 0) ? lkv_pkg::CMD_GET : lkv_pkg::CMD_PUT;
                if ($urandom_range(0, 9) < 8) key = key_pool[$urandom_range(0, pool_len - 1)];
                else key = $urandom;
                case ($urandom_range(0, 7))
                    0: value = 32'hFFFF_FFFF;
                    1: value = 32'h0000_0000;
                    2: value = 32'h8000_0000;
                    3: value = 32'h7FFF_FFFF;
                    default: value = $urandom;
                endcase
                queue_request(cmd, key, value);
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (expected_results.size() != 0)
            flag_mismatch("predicted results never returned",
                          lkv_pkg::VAL_W'(expected_results.size()), '0);

        $display("covered %0d requests (%0d puts), %0d results, %0d hits, %0d evictions",
                 n_requests, n_puts, n_results, n_hits, n_evicts);
        $display("capacities 0 to 31 incl. shrink below fill, long output hold-off; %0d mismatches",
                 mismatches);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/lkv_pkg.sv
rtl/lkv_cell.sv
rtl/lru_key_value_cache_top.sv
rtl/lkv_checker.sv
tb/tb.sv
